// ----- design/fppid_pkg.sv -----
// Package for the fixed-point PID controller core.
// Holds item structs, register indexes, state codes and shared widths.
// No dependencies.
package fppid_pkg;

   localparam int MUL_W = 18;
   localparam int PROD_W = 2 * MUL_W;
   localparam int MUL_CNT_W = $clog2(MUL_W);
   localparam int LP_SHIFT = 8;
   localparam int LP_SUM = 256;
   localparam int CSR_ADDR_W = 5;

   typedef struct packed {
      logic signed [15:0] setpoint;
      logic signed [15:0] measured;
   } req_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic               held;
   } rsp_type;

   typedef struct packed {
      logic                    start;
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [PROD_W-1:0] product;
   } mul_rsp_type;

   typedef enum logic [2:0] {
      REG_PROP_GAIN,
      REG_INTEG_GAIN,
      REG_DERIV_GAIN,
      REG_DEAD_ZONE,
      REG_SMOOTHING,
      REG_DRIVE_MIN,
      REG_DRIVE_MAX
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_MUL_I,
      ST_MUL_FA,
      ST_MUL_FB,
      ST_MUL_P,
      ST_MUL_D,
      ST_MUL_S,
      ST_OUT
   } state_type;

endpackage

// ----- design/fixed_point_pid_controller_core.sv -----
// Top level of the fixed-point PID controller: control sequencer, state and registers.
// Depends on fppid_pkg and fppid_serial_mult.
//
//  Channel  Direction  Handshake               Payload
//  req      in         req_valid / req_stall   req_data (setpoint, measured)
//  rsp      out        rsp_valid / rsp_stall   rsp_data (drive, held)
//  csr      in/out     APB-style, pready high  7 registers at byte address 4*i
//
// An item inside the dead zone skips the multiplier and goes from ST_ERR to
// ST_OUT. Any other item takes serial products: six with the filter on and
// four with it off. All of them share the single bit-serial multiplier.
// Reset is synchronous and resets the control state and settings, not the data registers;
// the result register holds an item while rsp_stall is high, and a new item is taken
// once the previous one has reached it.
module fixed_point_pid_controller_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  fppid_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output fppid_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [fppid_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import fppid_pkg::*;

   state_type state_ff, state_in;
   logic launched_ff, launched_in;

   logic signed [15:0] prop_ff, prop_in, integ_g_ff, integ_g_in, deriv_ff, deriv_in;
   logic        [15:0] dz_ff, dz_in;
   logic        [8:0]  ratio_ff, ratio_in;
   logic signed [15:0] dmin_ff, dmin_in, dmax_ff, dmax_in;

   logic signed [31:0] integ_ff, integ_in;
   logic signed [16:0] prev_ff, prev_in;
   logic               prev_valid_ff, prev_valid_in;
   logic signed [16:0] filt_ff, filt_in;
   logic signed [15:0] last_ff, last_in;

   req_type            item_ff, item_in;
   logic signed [15:0] err_ff, err_in;
   logic signed [17:0] diff_ff, diff_in;
   logic signed [PROD_W-1:0] pa_ff, pa_in;
   logic signed [33:0] sum_ff, sum_in;
   logic               held_ff, held_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   logic               csr_wr;
   reg_index_type      csr_idx;
   logic signed [16:0] raw_err, err17, mag;
   logic signed [15:0] err_c;
   logic        [17:0] ratio_eff, lp_a;
   logic signed [PROD_W-1:0] prod, shr9, shr10;
   logic signed [33:0] isum;
   logic signed [PROD_W-1:0] fsum;
   logic signed [15:0] o_c;
   logic        [15:0] u_val;
   logic signed [16:0] span;
   logic signed [18:0] scaled;

   fppid_serial_mult u_mult (
      .clock  (clock),
      .reset  (reset),
      .mul_req(mul_req),
      .mul_rsp(mul_rsp)
   );

   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = reg_index_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_idx)
         REG_PROP_GAIN:  csr_prdata = 32'(prop_ff);
         REG_INTEG_GAIN: csr_prdata = 32'(integ_g_ff);
         REG_DERIV_GAIN: csr_prdata = 32'(deriv_ff);
         REG_DEAD_ZONE:  csr_prdata = {16'd0, dz_ff};
         REG_SMOOTHING:  csr_prdata = {23'd0, ratio_ff};
         REG_DRIVE_MIN:  csr_prdata = 32'(dmin_ff);
         REG_DRIVE_MAX:  csr_prdata = 32'(dmax_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_comb begin
      raw_err = 17'(item_ff.measured) - 17'(item_ff.setpoint);
      if (raw_err > 17'sd32767) begin
         err_c = 16'sh7fff;
      end else if (raw_err < -17'sd32768) begin
         err_c = 16'sh8000;
      end else begin
         err_c = raw_err[15:0];
      end
      err17 = 17'(err_c);
      mag = err17[16] ? -err17 : err17;

      ratio_eff = (18'(ratio_ff) > 18'(LP_SUM)) ? 18'(LP_SUM) : 18'(ratio_ff);
      lp_a = 18'(LP_SUM) - ratio_eff;

      prod = mul_rsp.product;
      shr9 = prod >>> 9;
      shr10 = prod >>> 10;
      isum = 34'(integ_ff) + 34'(shr10);
      fsum = (pa_ff + prod) >>> LP_SHIFT;

      if (sum_ff > 34'sd32767) begin
         o_c = 16'sh7fff;
      end else if (sum_ff < -34'sd32768) begin
         o_c = 16'sh8000;
      end else begin
         o_c = sum_ff[15:0];
      end
      u_val = {~o_c[15], o_c[14:0]};
      span = 17'(dmax_ff) - 17'(dmin_ff);
      if (span < 0) begin
         span = '0;
      end
      scaled = $signed({2'b00, prod[32:16]}) + 19'(dmin_ff) + 19'sd1;
   end

   always_comb begin
      state_in = state_ff;
      launched_in = launched_ff;
      prop_in = prop_ff;
      integ_g_in = integ_g_ff;
      deriv_in = deriv_ff;
      dz_in = dz_ff;
      ratio_in = ratio_ff;
      dmin_in = dmin_ff;
      dmax_in = dmax_ff;
      integ_in = integ_ff;
      prev_in = prev_ff;
      prev_valid_in = prev_valid_ff;
      filt_in = filt_ff;
      last_in = last_ff;
      item_in = item_ff;
      err_in = err_ff;
      diff_in = diff_ff;
      pa_in = pa_ff;
      sum_in = sum_ff;
      held_in = held_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall = (state_ff != ST_IDLE);
      mul_req.start = 1'b0;
      mul_req.a = '0;
      mul_req.b = '0;

      unique case (state_ff)
         ST_MUL_I: begin
            mul_req.a = 18'(integ_g_ff);
            mul_req.b = 18'(err_ff);
         end
         ST_MUL_FA: begin
            mul_req.a = 18'(err_ff);
            mul_req.b = lp_a;
         end
         ST_MUL_FB: begin
            mul_req.a = 18'(filt_ff);
            mul_req.b = ratio_eff;
         end
         ST_MUL_P: begin
            mul_req.a = 18'(prop_ff);
            mul_req.b = 18'(filt_ff);
         end
         ST_MUL_D: begin
            mul_req.a = 18'(deriv_ff);
            mul_req.b = diff_ff;
         end
         ST_MUL_S: begin
            mul_req.a = {1'b0, span};
            mul_req.b = {2'b00, u_val};
         end
         default: begin
            mul_req.a = '0;
            mul_req.b = '0;
         end
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            err_in = err_c;
            if (mag < $signed({1'b0, dz_ff})) begin
               prev_in = '0;
               prev_valid_in = 1'b1;
               held_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               held_in = 1'b0;
               state_in = ST_MUL_I;
            end
         end
         ST_MUL_I, ST_MUL_FA, ST_MUL_FB, ST_MUL_P, ST_MUL_D, ST_MUL_S: begin
            mul_req.start = !launched_ff;
            launched_in = 1'b1;
            if (mul_rsp.done) begin
               launched_in = 1'b0;
               case (state_ff)
                  ST_MUL_I: begin
                     if (isum > 34'sd2147483647) begin
                        integ_in = 32'sh7fffffff;
                     end else if (isum < -34'sd2147483648) begin
                        integ_in = 32'sh80000000;
                     end else begin
                        integ_in = isum[31:0];
                     end
                     sum_in = 34'(integ_in);
                     diff_in = prev_valid_ff ? 18'(err_ff) - 18'(prev_ff) : '0;
                     prev_in = 17'(err_ff);
                     prev_valid_in = 1'b1;
                     if (ratio_eff != '0) begin
                        state_in = ST_MUL_FA;
                     end else begin
                        filt_in = 17'(err_ff);
                        state_in = ST_MUL_P;
                     end
                  end
                  ST_MUL_FA: begin
                     pa_in = prod;
                     state_in = ST_MUL_FB;
                  end
                  ST_MUL_FB: begin
                     if (fsum > 36'sd65535) begin
                        filt_in = 17'sh0ffff;
                     end else if (fsum < -36'sd65536) begin
                        filt_in = 17'sh10000;
                     end else begin
                        filt_in = fsum[16:0];
                     end
                     state_in = ST_MUL_P;
                  end
                  ST_MUL_P: begin
                     sum_in = sum_ff + 34'(shr9);
                     state_in = ST_MUL_D;
                  end
                  ST_MUL_D: begin
                     sum_in = sum_ff + 34'(shr9);
                     state_in = ST_MUL_S;
                  end
                  default: begin
                     if (scaled > 19'(dmax_ff)) begin
                        last_in = dmax_ff;
                     end else begin
                        last_in = scaled[15:0];
                     end
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.drive = last_ff;
               rsp_in.held = held_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr) begin
         unique case (csr_idx)
            REG_PROP_GAIN:  prop_in = csr_pwdata[15:0];
            REG_INTEG_GAIN: integ_g_in = csr_pwdata[15:0];
            REG_DERIV_GAIN: deriv_in = csr_pwdata[15:0];
            REG_DEAD_ZONE:  dz_in = csr_pwdata[15:0];
            REG_SMOOTHING:  ratio_in = csr_pwdata[8:0];
            REG_DRIVE_MIN:  dmin_in = csr_pwdata[15:0];
            REG_DRIVE_MAX:  dmax_in = csr_pwdata[15:0];
            default: ;
         endcase
         if (csr_idx == REG_PROP_GAIN || csr_idx == REG_INTEG_GAIN ||
             csr_idx == REG_DERIV_GAIN || csr_idx == REG_SMOOTHING) begin
            integ_in = '0;
            prev_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      err_ff <= err_in;
      diff_ff <= diff_in;
      pa_ff <= pa_in;
      sum_ff <= sum_in;
      held_ff <= held_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         launched_ff <= 1'b0;
         prop_ff <= '0;
         integ_g_ff <= '0;
         deriv_ff <= '0;
         dz_ff <= '0;
         ratio_ff <= '0;
         dmin_ff <= 16'sh8000;
         dmax_ff <= 16'sh7fff;
         integ_ff <= '0;
         prev_ff <= '0;
         prev_valid_ff <= 1'b0;
         filt_ff <= '0;
         last_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         launched_ff <= launched_in;
         prop_ff <= prop_in;
         integ_g_ff <= integ_g_in;
         deriv_ff <= deriv_in;
         dz_ff <= dz_in;
         ratio_ff <= ratio_in;
         dmin_ff <= dmin_in;
         dmax_ff <= dmax_in;
         integ_ff <= integ_in;
         prev_ff <= prev_in;
         prev_valid_ff <= prev_valid_in;
         filt_ff <= filt_in;
         last_ff <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while one is in progress");

   a_mult_idle: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> state_ff != ST_IDLE && state_ff != ST_OUT)
      else $error("product finished outside a multiply step");

   a_held_repeats: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && rsp_ff.held |-> rsp_ff.drive == last_ff)
      else $error("held item does not repeat the last drive");

endmodule

// ----- design/fppid_serial_mult.sv -----
// Bit-serial signed multiplier, one multiplier bit per cycle.
// Depends on fppid_pkg for widths and the request and response structs.
module fppid_serial_mult (
   input  logic                  clock,
   input  logic                  reset,
   input  fppid_pkg::mul_req_type mul_req,
   output fppid_pkg::mul_rsp_type mul_rsp
);
   import fppid_pkg::*;

   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] mc_ff, mc_in;
   logic        [MUL_W-1:0]  mp_ff, mp_in;
   logic        [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic signed [PROD_W-1:0] addend;

   always_comb begin
      acc_in = acc_ff;
      mc_in = mc_ff;
      mp_in = mp_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      addend = mp_ff[0] ? mc_ff : '0;
      if (mul_req.start) begin
         acc_in = '0;
         mc_in = PROD_W'(mul_req.a);
         mp_in = mul_req.b;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == MUL_CNT_W'(MUL_W - 1)) begin
            acc_in = acc_ff - addend;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            acc_in = acc_ff + addend;
         end
         mc_in = mc_ff <<< 1;
         mp_in = mp_ff >> 1;
         cnt_in = cnt_ff + MUL_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mc_ff <= mc_in;
      mp_ff <= mp_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule
